>>> hdl/bjc_pkg.sv
// ============================================================================
// bjc_pkg: shared types and codes of the bus join connection machine
// Holds the channel payload structs, the link state, frame and send codes,
// the timer slots and the configuration register map.
// ============================================================================
package bjc_pkg;

   localparam int TIMER_COUNT = 5;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int RESULT_COUNT_WIDTH = 4;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      LINK_DISCONNECTED = 2'd0,
      LINK_ASKING       = 2'd1,
      LINK_CONNECTING   = 2'd2,
      LINK_CONNECTED    = 2'd3
   } link_state_type;

   typedef enum logic [2:0] {
      SEND_UID        = 3'd0,
      SEND_CONFIGURE  = 3'd1,
      SEND_EXPECT_ID  = 3'd2,
      SEND_DISCONNECT = 3'd3,
      SEND_CONNECT    = 3'd4,
      SEND_REQUEST    = 3'd5,
      SEND_HEARTBEAT  = 3'd6
   } send_kind_type;

   localparam logic [2:0] FRAME_SRV_HEARTBEAT = 3'd0;
   localparam logic [2:0] FRAME_ALLOW         = 3'd1;
   localparam logic [2:0] FRAME_ASSIGNED_ID   = 3'd2;
   localparam logic [2:0] FRAME_DONE          = 3'd3;
   localparam logic [2:0] FRAME_LOST          = 3'd4;

   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   localparam int TM_RECONNECT  = 0;
   localparam int TM_ASK        = 1;
   localparam int TM_CONNECTING = 2;
   localparam int TM_HEARTBEAT  = 3;
   localparam int TM_SERVER     = 4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_UID_VALUE          = 3'd0,
      CSR_UID_LENGTH         = 3'd1,
      CSR_REASSIGN           = 3'd2,
      CSR_RECONNECT_PERIOD   = 3'd3,
      CSR_ASK_TIMEOUT        = 3'd4,
      CSR_CONNECTING_TIMEOUT = 3'd5,
      CSR_HEARTBEAT_PERIOD   = 3'd6,
      CSR_SERVER_TIMEOUT     = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      BURST_NONE   = 2'd0,
      BURST_ALLOW  = 2'd1,
      BURST_SINGLE = 2'd2
   } burst_type;

   typedef struct packed {
      logic       req_type;
      logic [2:0] frame_kind;
      logic       frame_remote;
      logic [7:0] frame_ident;
      logic       tx_empty;
   } req_payload_type;

   typedef struct packed {
      logic       send_valid;
      logic [2:0] send_kind;
      logic [7:0] send_ident;
      logic [1:0] link_state;
      logic [7:0] own_id;
      logic       last;
   } rsp_payload_type;

endpackage

>>> hdl/bus_join_connection_fsm_top.sv
// ============================================================================
// bus_join_connection_fsm_top: client join and keepalive machine
// Takes received frames and millisecond ticks, updates the link state, the
// held ID and five timers, and emits the frames to send and a status result.
// ============================================================================
//
//   channel  handshake            payload
//   req      req_valid/req_stall  req_payload_type, one frame or tick
//   rsp      rsp_valid/rsp_stall  rsp_payload_type, frames then status
//   csr      csr_valid/csr_ready  csr_index, csr_data, always ready
//
// An item is decided in the cycle it transfers; its results leave one per
// cycle from the result register while rsp is not stalled, so an item with
// k frames yields k + 1 results, the frames and then the status result.
// The next item transfers in the cycle the previous status result transfers.
// A stall on rsp holds the result register and stalls req.
// Reset is synchronous; no clearing pass is needed.
module bus_join_connection_fsm_top
   import bjc_pkg::*;
#(
   parameter int UID_MAX_BYTES = 8,
   parameter int CONFIG_CODE = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   logic [63:0] uid_value_ff;
   logic [3:0]  uid_length_ff;
   logic        reassign_ff;
   logic [15:0] period_ff [TIMER_COUNT];

   link_state_type state_ff, state_in;
   logic [7:0]     held_ff, held_in;
   logic [15:0]    tcount_ff [TIMER_COUNT];
   logic [15:0]    tcount_in [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] trun_ff, trun_in;

   logic                          burst_valid_ff, burst_valid_in;
   logic [RESULT_COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   burst_type                     burst_ff, burst_in;
   send_kind_type                 kind_ff, kind_in;
   logic [7:0]                    ident_ff, ident_in;
   logic [3:0]                    uid_n_ff, uid_n_in;
   link_state_type                final_state_ff;
   logic [7:0]                    final_held_ff;

   logic accept;
   logic rsp_done;
   logic rsp_last;

   assign csr_ready = 1'b1;
   assign rsp_valid = burst_valid_ff;
   assign rsp_done  = burst_valid_ff && !rsp_stall && rsp_last;
   assign req_stall = burst_valid_ff && !rsp_done;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         uid_value_ff  <= '0;
         uid_length_ff <= 4'd8;
         reassign_ff   <= 1'b0;
         period_ff[TM_RECONNECT]  <= 16'd1000;
         period_ff[TM_ASK]        <= 16'd500;
         period_ff[TM_CONNECTING] <= 16'd5000;
         period_ff[TM_HEARTBEAT]  <= 16'd1000;
         period_ff[TM_SERVER]     <= 16'd2500;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_UID_VALUE:          uid_value_ff  <= csr_data;
            CSR_UID_LENGTH:         uid_length_ff <= csr_data[3:0];
            CSR_REASSIGN:           reassign_ff   <= csr_data[0];
            CSR_RECONNECT_PERIOD:   period_ff[TM_RECONNECT]  <= csr_data[15:0];
            CSR_ASK_TIMEOUT:        period_ff[TM_ASK]        <= csr_data[15:0];
            CSR_CONNECTING_TIMEOUT: period_ff[TM_CONNECTING] <= csr_data[15:0];
            CSR_HEARTBEAT_PERIOD:   period_ff[TM_HEARTBEAT]  <= csr_data[15:0];
            CSR_SERVER_TIMEOUT:     period_ff[TM_SERVER]     <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= LINK_DISCONNECTED;
         held_ff        <= '0;
         trun_ff        <= TIMER_COUNT'(1) << TM_RECONNECT;
         burst_valid_ff <= 1'b0;
         cnt_ff         <= '0;
         for (int t = 0; t < TIMER_COUNT; t++) begin
            tcount_ff[t] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         held_ff        <= held_in;
         trun_ff        <= trun_in;
         burst_valid_ff <= burst_valid_in;
         cnt_ff         <= cnt_in;
         tcount_ff      <= tcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         burst_ff       <= burst_in;
         kind_ff        <= kind_in;
         ident_ff       <= ident_in;
         uid_n_ff       <= uid_n_in;
         final_state_ff <= state_in;
         final_held_ff  <= held_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      held_in   = held_ff;
      tcount_in = tcount_ff;
      trun_in   = trun_ff;
      burst_in  = BURST_NONE;
      kind_in   = SEND_UID;
      ident_in  = '0;
      uid_n_in  = '0;
      if (accept) begin
         if (req_payload.req_type == REQ_FRAME) begin
            if (req_payload.frame_remote) begin
               if (req_payload.frame_kind == FRAME_SRV_HEARTBEAT) begin
                  tcount_in[TM_SERVER] = '0;
                  trun_in[TM_SERVER]   = 1'b1;
               end
            end else begin
               case (req_payload.frame_kind)
                  FRAME_ALLOW: begin
                     state_in = LINK_CONNECTING;
                     tcount_in[TM_CONNECTING] = '0;
                     trun_in[TM_CONNECTING]   = 1'b1;
                     burst_in = BURST_ALLOW;
                     uid_n_in = (32'(uid_length_ff) > UID_MAX_BYTES) ?
                                4'(UID_MAX_BYTES) : uid_length_ff;
                  end
                  FRAME_ASSIGNED_ID: begin
                     if (state_ff == LINK_CONNECTING) begin
                        burst_in = BURST_SINGLE;
                        ident_in = req_payload.frame_ident;
                        if (req_payload.frame_ident == 8'd0 ||
                            (held_ff != 8'd0 && req_payload.frame_ident != held_ff &&
                             !reassign_ff)) begin
                           kind_in  = SEND_DISCONNECT;
                           state_in = LINK_DISCONNECTED;
                           tcount_in[TM_RECONNECT] = '0;
                           trun_in[TM_RECONNECT]   = 1'b1;
                        end else begin
                           kind_in = SEND_CONNECT;
                           held_in = req_payload.frame_ident;
                        end
                     end
                  end
                  FRAME_DONE: begin
                     if (state_ff == LINK_CONNECTING) begin
                        state_in = LINK_CONNECTED;
                        tcount_in[TM_HEARTBEAT] = '0;
                        trun_in[TM_HEARTBEAT]   = 1'b1;
                        tcount_in[TM_SERVER]    = '0;
                        trun_in[TM_SERVER]      = 1'b1;
                     end
                  end
                  FRAME_LOST: begin
                     state_in = LINK_DISCONNECTED;
                     tcount_in[TM_RECONNECT] = '0;
                     trun_in[TM_RECONNECT]   = 1'b1;
                  end
                  default: ;
               endcase
            end
         end else begin
            for (int t = 0; t < TIMER_COUNT; t++) begin
               if (trun_ff[t] && tcount_ff[t] != COUNT_MAX) begin
                  tcount_in[t] = tcount_ff[t] + 16'd1;
               end
            end
            case (state_ff)
               LINK_DISCONNECTED: begin
                  if (trun_ff[TM_RECONNECT] &&
                      tcount_in[TM_RECONNECT] >= period_ff[TM_RECONNECT]) begin
                     trun_in[TM_RECONNECT] = 1'b0;
                     state_in = LINK_ASKING;
                     tcount_in[TM_ASK] = '0;
                     trun_in[TM_ASK]   = 1'b1;
                     burst_in = BURST_SINGLE;
                     kind_in  = SEND_REQUEST;
                     ident_in = held_ff;
                  end
               end
               LINK_ASKING: begin
                  if (trun_ff[TM_ASK] && tcount_in[TM_ASK] >= period_ff[TM_ASK]) begin
                     state_in = LINK_DISCONNECTED;
                     tcount_in[TM_RECONNECT] = '0;
                     trun_in[TM_RECONNECT]   = 1'b1;
                     trun_in[TM_ASK]         = 1'b0;
                  end
               end
               LINK_CONNECTING: begin
                  if (trun_ff[TM_CONNECTING] &&
                      tcount_in[TM_CONNECTING] >= period_ff[TM_CONNECTING]) begin
                     state_in = LINK_DISCONNECTED;
                     tcount_in[TM_RECONNECT] = '0;
                     trun_in[TM_RECONNECT]   = 1'b1;
                     trun_in[TM_CONNECTING]  = 1'b0;
                  end
               end
               default: begin
                  if (req_payload.tx_empty) begin
                     if (trun_ff[TM_HEARTBEAT] &&
                         tcount_in[TM_HEARTBEAT] >= period_ff[TM_HEARTBEAT]) begin
                        tcount_in[TM_HEARTBEAT] = '0;
                        burst_in = BURST_SINGLE;
                        kind_in  = SEND_HEARTBEAT;
                        ident_in = held_ff;
                     end
                     if (trun_ff[TM_SERVER] &&
                         tcount_in[TM_SERVER] >= period_ff[TM_SERVER]) begin
                        state_in = LINK_DISCONNECTED;
                        tcount_in[TM_RECONNECT] = '0;
                        trun_in[TM_RECONNECT]   = 1'b1;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      burst_valid_in = burst_valid_ff;
      cnt_in         = cnt_ff;
      if (accept) begin
         burst_valid_in = 1'b1;
         cnt_in         = '0;
      end else if (rsp_done) begin
         burst_valid_in = 1'b0;
      end else if (burst_valid_ff && !rsp_stall) begin
         cnt_in = cnt_ff + RESULT_COUNT_WIDTH'(1);
      end
   end

   always_comb begin
      rsp_payload.send_valid = 1'b0;
      rsp_payload.send_kind  = '0;
      rsp_payload.send_ident = '0;
      rsp_payload.link_state = final_state_ff;
      rsp_payload.own_id     = final_held_ff;
      rsp_payload.last       = 1'b1;
      case (burst_ff)
         BURST_ALLOW: begin
            if (cnt_ff < uid_n_ff) begin
               rsp_payload.send_valid = 1'b1;
               rsp_payload.send_kind  = SEND_UID;
               rsp_payload.send_ident = uid_value_ff[cnt_ff[2:0]*8 +: 8];
               rsp_payload.last       = 1'b0;
            end else if (cnt_ff == uid_n_ff) begin
               rsp_payload.send_valid = 1'b1;
               rsp_payload.send_kind  = SEND_CONFIGURE;
               rsp_payload.send_ident = 8'(CONFIG_CODE);
               rsp_payload.last       = 1'b0;
            end else if (cnt_ff == uid_n_ff + 4'd1) begin
               rsp_payload.send_valid = 1'b1;
               rsp_payload.send_kind  = SEND_EXPECT_ID;
               rsp_payload.send_ident = final_held_ff;
               rsp_payload.last       = 1'b0;
            end
         end
         BURST_SINGLE: begin
            if (cnt_ff == '0) begin
               rsp_payload.send_valid = 1'b1;
               rsp_payload.send_kind  = kind_ff;
               rsp_payload.send_ident = ident_ff;
               rsp_payload.last       = 1'b0;
            end
         end
         default: ;
      endcase
   end

   assign rsp_last = rsp_payload.last;

endmodule

>>> hdl/bjc_checker.sv
// ============================================================================
// bjc_checker: port-level checks for the bus join connection machine
// Watches the request and result channels and is bound to the top level.
// ============================================================================
module bjc_checker
   import bjc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last |=> rsp_valid)
      else $error("result burst ended without a status result");

   a_status_no_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last != rsp_payload.send_valid))
      else $error("status and frame flags disagree");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while the result register is blocked");

endmodule

bind bus_join_connection_fsm_top bjc_checker u_bjc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

>>> verif/bjc_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ============================================================================
// bjc_scoreboard_pkg: expected-result store for the bus join machine
// Mirrors the link state, held ID, timers and registers of the block, turns
// each accepted frame or tick into the frames to send plus a status result,
// and checks every result transfer against the oldest expected one.
// ============================================================================
package bjc_scoreboard_pkg;
   import bjc_pkg::*;

   localparam int MAX_UID_BYTES = 8;
   localparam logic [7:0] CONFIG_BYTE = 8'd0;

   class join_scoreboard;
      logic [63:0] uid_value;
      logic [3:0] uid_length;
      logic reassign_ok;
      logic [15:0] reconnect_period;
      logic [15:0] ask_timeout;
      logic [15:0] connecting_timeout;
      logic [15:0] heartbeat_period;
      logic [15:0] server_timeout;

      link_state_type link;
      logic [7:0] held_id;
      logic [15:0] count [TIMER_COUNT];
      bit running [TIMER_COUNT];

      rsp_payload_type frames_q[$];
      rsp_payload_type expected_q[$];

      int errors;
      int inputs_seen;
      int results_seen;
      int connects;
      int rejects;
      int heartbeats;

      function new();
         uid_value = '0;
         uid_length = 4'd8;
         reassign_ok = 1'b0;
         reconnect_period = 16'd1000;
         ask_timeout = 16'd500;
         connecting_timeout = 16'd5000;
         heartbeat_period = 16'd1000;
         server_timeout = 16'd2500;
         link = LINK_DISCONNECTED;
         held_id = '0;
         for (int t = 0; t < TIMER_COUNT; t++) begin
            count[t] = '0;
            running[t] = 1'b0;
         end
         running[TM_RECONNECT] = 1'b1;
         errors = 0;
         inputs_seen = 0;
         results_seen = 0;
         connects = 0;
         rejects = 0;
         heartbeats = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void write_register(csr_index_type idx, logic [63:0] d);
         case (idx)
            CSR_UID_VALUE: uid_value = d;
            CSR_UID_LENGTH: uid_length = d[3:0];
            CSR_REASSIGN: reassign_ok = d[0];
            CSR_RECONNECT_PERIOD: reconnect_period = d[15:0];
            CSR_ASK_TIMEOUT: ask_timeout = d[15:0];
            CSR_CONNECTING_TIMEOUT: connecting_timeout = d[15:0];
            CSR_HEARTBEAT_PERIOD: heartbeat_period = d[15:0];
            CSR_SERVER_TIMEOUT: server_timeout = d[15:0];
            default: ;
         endcase
      endfunction

      function void start_timer(int t);
         count[t] = '0;
         running[t] = 1'b1;
      endfunction

      function bit expired(int t, logic [15:0] period);
         return running[t] && (count[t] >= period);
      endfunction

      function void enter(link_state_type s);
         link = s;
         case (s)
            LINK_DISCONNECTED: start_timer(TM_RECONNECT);
            LINK_CONNECTING: start_timer(TM_CONNECTING);
            LINK_CONNECTED: begin
               start_timer(TM_HEARTBEAT);
               start_timer(TM_SERVER);
               connects++;
            end
            default: ;
         endcase
      endfunction

      function void queue_frame(send_kind_type k, logic [7:0] id);
         rsp_payload_type f;
         f = '0;
         f.send_valid = 1'b1;
         f.send_kind = k;
         f.send_ident = id;
         frames_q.push_back(f);
      endfunction

      function void take_frame(logic [2:0] kind, logic remote, logic [7:0] ident);
         int n;
         if (remote) begin
            if (kind == FRAME_SRV_HEARTBEAT) start_timer(TM_SERVER);
            return;
         end
         case (kind)
            FRAME_ALLOW: begin
               if (uid_length > MAX_UID_BYTES) n = MAX_UID_BYTES;
               else n = uid_length;
               enter(LINK_CONNECTING);
               for (int i = 0; i < n; i++) queue_frame(SEND_UID, uid_value[8*i +: 8]);
               queue_frame(SEND_CONFIGURE, CONFIG_BYTE);
               queue_frame(SEND_EXPECT_ID, held_id);
            end
            FRAME_ASSIGNED_ID: begin
               if (link == LINK_CONNECTING) begin
                  if (ident == 8'd0 ||
                      (held_id != 8'd0 && ident != held_id && !reassign_ok)) begin
                     queue_frame(SEND_DISCONNECT, ident);
                     enter(LINK_DISCONNECTED);
                     rejects++;
                  end else begin
                     held_id = ident;
                     queue_frame(SEND_CONNECT, ident);
                  end
               end
            end
            FRAME_DONE: begin
               if (link == LINK_CONNECTING) enter(LINK_CONNECTED);
            end
            FRAME_LOST: enter(LINK_DISCONNECTED);
            default: ;
         endcase
      endfunction

      function void take_tick(logic tx_empty);
         for (int t = 0; t < TIMER_COUNT; t++) begin
            if (running[t] && count[t] != COUNT_MAX) count[t]++;
         end
         case (link)
            LINK_DISCONNECTED: begin
               if (expired(TM_RECONNECT, reconnect_period)) begin
                  running[TM_RECONNECT] = 1'b0;
                  enter(LINK_ASKING);
                  start_timer(TM_ASK);
                  queue_frame(SEND_REQUEST, held_id);
               end
            end
            LINK_ASKING: begin
               if (expired(TM_ASK, ask_timeout)) begin
                  enter(LINK_DISCONNECTED);
                  running[TM_ASK] = 1'b0;
               end
            end
            LINK_CONNECTING: begin
               if (expired(TM_CONNECTING, connecting_timeout)) begin
                  enter(LINK_DISCONNECTED);
                  running[TM_CONNECTING] = 1'b0;
               end
            end
            default: begin
               if (tx_empty) begin
                  if (expired(TM_HEARTBEAT, heartbeat_period)) begin
                     start_timer(TM_HEARTBEAT);
                     queue_frame(SEND_HEARTBEAT, held_id);
                     heartbeats++;
                  end
                  if (expired(TM_SERVER, server_timeout)) enter(LINK_DISCONNECTED);
               end
            end
         endcase
      endfunction

      function void note_input(req_payload_type p);
         rsp_payload_type s;
         inputs_seen++;
         frames_q.delete();
         if (p.req_type == REQ_FRAME) take_frame(p.frame_kind, p.frame_remote, p.frame_ident);
         else take_tick(p.tx_empty);
         foreach (frames_q[i]) begin
            s = frames_q[i];
            s.link_state = link;
            s.own_id = held_id;
            expected_q.push_back(s);
         end
         s = '0;
         s.link_state = link;
         s.own_id = held_id;
         s.last = 1'b1;
         expected_q.push_back(s);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("mismatch %0d: %s", errors, what);
      endtask

      task check_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("result %0d %s is 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
         end
      endtask

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
            return;
         end
         want = expected_q.pop_front();
         check_field("send_valid", 8'(got.send_valid), 8'(want.send_valid));
         check_field("send_kind", 8'(got.send_kind), 8'(want.send_kind));
         check_field("send_ident", got.send_ident, want.send_ident);
         check_field("link_state", 8'(got.link_state), 8'(want.link_state));
         check_field("own_id", got.own_id, want.own_id);
         check_field("last", 8'(got.last), 8'(want.last));
      endtask
   endclass

endpackage

>>> verif/tb_bus_join_connection_fsm_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_bus_join_connection_fsm_top: testbench of the bus join connection machine
// Drives received frames and ticks through a join handshake, keepalive and
// timeout directed part, then well-formed join sequences mixed with noise
// under several register settings and idling patterns, and a short tick run
// with the largest periods. Every result transfer is checked in order.
// ============================================================================
module tb_bus_join_connection_fsm_top;
   import bjc_pkg::*;
   import bjc_scoreboard_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int settings_used = 0;
   join_scoreboard sb = new();

   bus_join_connection_fsm_top #(
      .UID_MAX_BYTES(MAX_UID_BYTES),
      .CONFIG_CODE(int'(CONFIG_BYTE))
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_input(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
         if (csr_valid && csr_ready) sb.write_register(csr_index_type'(csr_index), csr_data);
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function req_payload_type frame_item(logic [2:0] kind, logic remote, logic [7:0] ident);
      req_payload_type p;
      p.req_type = REQ_FRAME;
      p.frame_kind = kind;
      p.frame_remote = remote;
      p.frame_ident = ident;
      p.tx_empty = 1'($urandom_range(1));
      return p;
   endfunction

   function req_payload_type tick_item(logic tx);
      req_payload_type p;
      p.req_type = REQ_TICK;
      p.frame_kind = 3'($urandom_range(7));
      p.frame_remote = 1'($urandom_range(1));
      p.frame_ident = 8'($urandom_range(255));
      p.tx_empty = tx;
      return p;
   endfunction

   task send_item(input req_payload_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task drain(input int bound);
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      @(posedge clock);
      while (sb.pending() != 0 && waited < bound) begin
         @(posedge clock);
         waited++;
      end
      repeat (12) @(posedge clock);
   endtask

   task write_csr(input csr_index_type idx, input logic [63:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task apply_setting(input logic [63:0] uid, input logic [3:0] len, input logic reassign_ok,
                      input logic [15:0] recon, input logic [15:0] ask,
                      input logic [15:0] conn, input logic [15:0] hb,
                      input logic [15:0] srv);
      drain(5000);
      write_csr(CSR_UID_VALUE, uid);
      write_csr(CSR_UID_LENGTH, 64'(len));
      write_csr(CSR_REASSIGN, 64'(reassign_ok));
      write_csr(CSR_RECONNECT_PERIOD, 64'(recon));
      write_csr(CSR_ASK_TIMEOUT, 64'(ask));
      write_csr(CSR_CONNECTING_TIMEOUT, 64'(conn));
      write_csr(CSR_HEARTBEAT_PERIOD, 64'(hb));
      write_csr(CSR_SERVER_TIMEOUT, 64'(srv));
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   function logic [15:0] pick_period();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 16'd0;
      if (r < 12) return 16'd1;
      if (r < 16) return COUNT_MAX;
      return 16'($urandom_range(12, 2));
   endfunction

   task apply_random_setting();
      logic [63:0] uid;
      int r;
      r = $urandom_range(99);
      if (r < 15) uid = '0;
      else if (r < 30) uid = '1;
      else uid = {$urandom, $urandom};
      apply_setting(uid, 4'($urandom_range(15)), 1'($urandom_range(1)), pick_period(),
                    pick_period(), pick_period(), pick_period(), pick_period());
   endtask

   task join_sequence();
      logic [7:0] id;
      int r;
      repeat ($urandom_range(3)) send_item(tick_item($urandom_range(99) < 80));
      send_item(frame_item(FRAME_ALLOW, 1'b0, 8'($urandom_range(255))));
      if ($urandom_range(3) == 0) send_item(tick_item(1'b1));
      r = $urandom_range(99);
      if (r < 15) id = 8'd0;
      else if (r < 30 || sb.held_id == 8'd0) id = 8'($urandom_range(255, 1));
      else id = sb.held_id;
      send_item(frame_item(FRAME_ASSIGNED_ID, 1'b0, id));
      send_item(frame_item(FRAME_DONE, 1'b0, 8'($urandom_range(255))));
      repeat ($urandom_range(8, 2)) begin
         if ($urandom_range(99) < 75) begin
            send_item(tick_item($urandom_range(99) < 80));
         end else begin
            send_item(frame_item(FRAME_SRV_HEARTBEAT, 1'b1, 8'($urandom_range(255))));
         end
      end
      if ($urandom_range(99) < 30) send_item(frame_item(FRAME_LOST, 1'b0, 8'($urandom_range(255))));
   endtask

   task run_random(input int count);
      int start;
      int noise;
      int r;
      start = sb.inputs_seen;
      noise = 0;
      while (sb.inputs_seen - start - noise < count) begin
         r = $urandom_range(99);
         if (r < 60) begin
            join_sequence();
         end else if (r < 80) begin
            repeat ($urandom_range(6, 1)) send_item(tick_item($urandom_range(99) < 70));
         end else begin
            send_item(req_payload_type'(14'($urandom_range(16383))));
            noise++;
         end
      end
   endtask

   initial begin
      logic [7:0] soak_id;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(frame_item(FRAME_ALLOW, 1'b0, 8'h00));
      apply_setting(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0, 16'd2, 16'd3, 16'd4, 16'd2, 16'd5);
      send_item(frame_item(FRAME_LOST, 1'b0, 8'h00));
      send_item(tick_item(1'b1));
      send_item(tick_item(1'b0));
      repeat (3) send_item(tick_item(1'b1));
      send_item(frame_item(FRAME_ALLOW, 1'b0, 8'hFF));
      send_item(frame_item(FRAME_ASSIGNED_ID, 1'b0, 8'h00));
      send_item(frame_item(FRAME_ALLOW, 1'b0, 8'h00));
      send_item(frame_item(FRAME_ASSIGNED_ID, 1'b0, 8'hFF));
      send_item(frame_item(FRAME_DONE, 1'b0, 8'h00));
      send_item(frame_item(FRAME_SRV_HEARTBEAT, 1'b1, 8'h00));
      send_item(frame_item(FRAME_ALLOW, 1'b1, 8'h55));
      send_item(frame_item(FRAME_SRV_HEARTBEAT, 1'b0, 8'h01));
      send_item(frame_item(3'd5, 1'b0, 8'h80));
      send_item(frame_item(3'd7, 1'b0, 8'hAA));
      send_item(tick_item(1'b0));
      send_item(tick_item(1'b1));
      send_item(tick_item(1'b1));
      send_item(frame_item(FRAME_ASSIGNED_ID, 1'b0, 8'h12));
      send_item(frame_item(FRAME_DONE, 1'b0, 8'h00));
      send_item(frame_item(FRAME_ALLOW, 1'b0, 8'h00));
      send_item(frame_item(FRAME_ASSIGNED_ID, 1'b0, 8'h5A));
      send_item(frame_item(FRAME_ALLOW, 1'b0, 8'h00));
      repeat (4) send_item(tick_item(1'b1));

      send_idle_pct = 37;
      recv_idle_pct = 54;
      apply_setting('1, 4'd15, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_random(62);
      apply_random_setting();
      run_random(62);

      send_idle_pct = 54;
      recv_idle_pct = 37;
      apply_setting('0, 4'd0, 1'b0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      run_random(62);
      apply_random_setting();
      run_random(62);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_random_setting();
      run_random(62);
      apply_random_setting();
      run_random(62);

      // Short tick run with the largest periods: no timer expires.
      apply_setting({$urandom, $urandom}, 4'd8, 1'b0, COUNT_MAX, COUNT_MAX, COUNT_MAX,
                    COUNT_MAX, COUNT_MAX);
      soak_id = (sb.held_id == 8'd0) ? 8'h01 : sb.held_id;
      send_item(frame_item(FRAME_ALLOW, 1'b0, 8'h00));
      send_item(frame_item(FRAME_ASSIGNED_ID, 1'b0, soak_id));
      send_item(frame_item(FRAME_DONE, 1'b0, 8'h00));
      repeat (8) send_item(tick_item(1'b0));
      send_item(tick_item(1'b1));
      send_item(tick_item(1'b1));

      drain(20000);
      if (sb.pending() != 0) begin
         sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
      end
      $display("Run covered %0d input transfers and %0d result transfers over %0d settings.",
               sb.inputs_seen, sb.results_seen, settings_used);
      $display("The link came up %0d times, rejected %0d assigned IDs and sent %0d heartbeats.",
               sb.connects, sb.rejects, sb.heartbeats);
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Run stopped at the time limit.");
      $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> files.f
hdl/bjc_pkg.sv
hdl/bus_join_connection_fsm_top.sv
hdl/bjc_checker.sv
verif/bjc_scoreboard_pkg.sv
verif/tb_bus_join_connection_fsm_top.sv
